/* src/drrc_pkg.sv */
package drrc_pkg;

	localparam int KEY_W = 16;
	localparam int SLICE_W = 32;
	localparam int OUT_W = 32;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_TOP = 16'h8000;
	localparam logic [7:0] BYTE_TOP = 8'h80;

	typedef struct packed {
		logic take_byte;
		logic clear_step;
		logic commit;
	} drrc_cmd_t;

	typedef struct packed {
		logic clear_done;
	} drrc_sts_t;

	// Folds one byte, most significant bit first, into the running CRC.
	function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic top_bit;
		logic in_bit;
		c = crc;
		for (int j = 0; j < 8; j++) begin
			top_bit = (c & CRC_TOP) != 16'h0000;
			in_bit = (b & (BYTE_TOP >> j)) != 8'h00;
			c = {c[14:0], 1'b0};
			if (top_bit != in_bit) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

/* src/drrc_if.sv */
interface drrc_in_if import drrc_pkg::*; ();
	logic valid;
	logic ready;
	logic [7:0] name_byte;
	logic last_byte;
	logic [SLICE_W-1:0] time_slice;

	modport source (output valid, output name_byte, output last_byte, output time_slice,
		input ready);
	modport sink (input valid, input name_byte, input last_byte, input time_slice,
		output ready);
endinterface

interface drrc_out_if import drrc_pkg::*; ();
	logic valid;
	logic ready;
	logic [KEY_W-1:0] domain_key;
	logic [OUT_W-1:0] request_count;
	logic new_domain;
	logic [OUT_W-1:0] domain_total;

	modport source (output valid, output domain_key, output request_count,
		output new_domain, output domain_total, input ready);
	modport sink (input valid, input domain_key, input request_count,
		input new_domain, input domain_total, output ready);
endinterface

/* src/drrc_ctrl.sv */
module drrc_ctrl import drrc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	input  logic      out_ready,
	output logic      out_valid,
	input  drrc_sts_t sts,
	output drrc_cmd_t cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic out_valid_q;
	logic accept;
	logic commit;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign commit = (state_q == ST_UPDATE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	assign cmd.take_byte = accept;
	assign cmd.clear_step = (state_q == ST_CLEAR);
	assign cmd.commit = commit;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && in_last) begin
					state_next = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (commit) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_last_goes_update: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> state_q == ST_UPDATE)
		else $error("last byte did not start a table update");
	a_commit_shows_word: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("committed result not presented");
	a_clear_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !out_valid_q)
		else $error("result word present during table clear");
	a_stall_holds_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE && out_valid_q && !out_ready |=> state_q == ST_UPDATE)
		else $error("update left while output stalled");

endmodule

/* src/drrc_datapath.sv */
module drrc_datapath import drrc_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  drrc_cmd_t          cmd,
	output drrc_sts_t          sts,
	input  logic [7:0]         name_byte,
	input  logic               last_byte,
	input  logic [SLICE_W-1:0] time_slice,
	output logic [KEY_W-1:0]   domain_key,
	output logic [OUT_W-1:0]   request_count,
	output logic               new_domain,
	output logic [OUT_W-1:0]   domain_total
);

	localparam int EntW = 1 + COUNT_BITS + SLICE_W;
	localparam int TableDepth = 1 << KEY_W;
	localparam int WideW = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

	logic [EntW-1:0] entry_mem_q [TableDepth];
	logic [EntW-1:0] rd_q;
	logic [KEY_W-1:0] crc_q;
	logic [KEY_W-1:0] crc_next;
	logic [KEY_W-1:0] key_q;
	logic [SLICE_W-1:0] slice_q;
	logic [KEY_W-1:0] clr_addr_q;
	logic [OUT_W-1:0] total_q;
	logic [OUT_W-1:0] total_next;

	logic hit;
	logic [COUNT_BITS-1:0] old_cnt;
	logic [SLICE_W-1:0] old_slice;
	logic [COUNT_BITS-1:0] cnt_next;
	logic [WideW-1:0] cnt_wide;

	logic [KEY_W-1:0] key_out_q;
	logic [OUT_W-1:0] count_out_q;
	logic new_out_q;
	logic [OUT_W-1:0] total_out_q;

	assign crc_next = fold_byte(crc_q, name_byte);
	assign sts.clear_done = &clr_addr_q;

	assign hit = rd_q[EntW-1];
	assign old_cnt = rd_q[SLICE_W +: COUNT_BITS];
	assign old_slice = rd_q[SLICE_W-1:0];

	always_comb begin
		if (!hit || (old_slice != slice_q)) begin
			cnt_next = COUNT_BITS'(1);
		end else if (&old_cnt) begin
			cnt_next = old_cnt;
		end else begin
			cnt_next = old_cnt + 1'b1;
		end
		if (!hit && !(&total_q)) begin
			total_next = total_q + 1'b1;
		end else begin
			total_next = total_q;
		end
	end

	assign cnt_wide = WideW'(cnt_next);

	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			entry_mem_q[clr_addr_q] <= '0;
		end else if (cmd.commit) begin
			entry_mem_q[key_q] <= {1'b1, cnt_next, slice_q};
		end
		if (cmd.take_byte && last_byte) begin
			rd_q <= entry_mem_q[crc_next];
			key_q <= crc_next;
			slice_q <= time_slice;
		end
		if (cmd.commit) begin
			key_out_q <= key_q;
			if (cnt_wide > WideW'({OUT_W{1'b1}})) begin
				count_out_q <= '1;
			end else begin
				count_out_q <= cnt_wide[OUT_W-1:0];
			end
			new_out_q <= !hit;
			total_out_q <= total_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
			clr_addr_q <= '0;
			total_q <= '0;
		end else begin
			if (cmd.take_byte) begin
				crc_q <= last_byte ? '0 : crc_next;
			end
			if (cmd.clear_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.commit) begin
				total_q <= total_next;
			end
		end
	end

	assign domain_key = key_out_q;
	assign request_count = count_out_q;
	assign new_domain = new_out_q;
	assign domain_total = total_out_q;

	a_crc_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_byte && last_byte |=> crc_q == '0)
		else $error("running CRC not restarted after last byte");

endmodule

/* src/domain_request_rate_counter.sv */
// Counts requests per domain name, keyed by the CRC-16 (polynomial 0x1021,
// initial value 0) of the name, in a table of 65536 entries.
// The req channel carries one name byte per word, with last_byte marking
// the final byte and time_slice sampled with it. The rsp channel carries
// one word per name: the key, the request count in the current slice,
// whether the entry was created, and the number of distinct keys so far.
// A byte that is not the last is taken and gives no word. The last byte
// leads to a read and then a write of the table entry on the single
// memory port. The edge that takes the last byte registers the read; the
// write, which a stall on rsp can hold back, loads the rsp word into an
// output register that holds it, so the next name's bytes are accepted
// while it waits; only the next table write waits on a stall.
// After reset the block clears the table one entry per cycle, with
// req.ready low during that pass.
module domain_request_rate_counter import drrc_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	drrc_in_if.sink req,
	drrc_out_if.source rsp
);

	drrc_cmd_t cmd;
	drrc_sts_t sts;

	drrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_last   (req.last_byte),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	drrc_datapath #(
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.name_byte     (req.name_byte),
		.last_byte     (req.last_byte),
		.time_slice    (req.time_slice),
		.domain_key    (rsp.domain_key),
		.request_count (rsp.request_count),
		.new_domain    (rsp.new_domain),
		.domain_total  (rsp.domain_total)
	);

endmodule

/* test/drrc_checker.sv */
module drrc_checker import drrc_pkg::*; (
	input logic clk,
	input logic arst_n,
	drrc_in_if req,
	drrc_out_if rsp,
	output int unsigned fail_count,
	output int unsigned pending
);

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [OUT_W-1:0] count;
		logic fresh;
		logic [OUT_W-1:0] total;
	} tally_t;

	tally_t tally_q[$];
	logic [OUT_W-1:0] count_of[int unsigned];
	logic [SLICE_W-1:0] slice_of[int unsigned];
	logic [KEY_W-1:0] name_crc = '0;
	logic [OUT_W-1:0] distinct = '0;

	function automatic logic [KEY_W-1:0] crc_add_byte(input logic [KEY_W-1:0] crc,
		input logic [7:0] b);
		logic [KEY_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[KEY_W-1] ? ({c[KEY_W-2:0], 1'b0} ^ CRC_POLY) : {c[KEY_W-2:0], 1'b0};
		end
		return c;
	endfunction

	always @(posedge clk) begin : watch
		tally_t t;
		tally_t got;
		int unsigned k;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				name_crc = crc_add_byte(name_crc, req.name_byte);
				if (req.last_byte) begin
					t.key = name_crc;
					k = 32'(name_crc);
					name_crc = '0;
					if (!count_of.exists(k)) begin
						count_of[k] = 1;
						slice_of[k] = req.time_slice;
						if (distinct != '1) begin
							distinct = distinct + 1;
						end
						t.fresh = 1'b1;
					end else begin
						if (slice_of[k] != req.time_slice) begin
							slice_of[k] = req.time_slice;
							count_of[k] = '0;
						end
						if (count_of[k] != '1) begin
							count_of[k] = count_of[k] + 1;
						end
						t.fresh = 1'b0;
					end
					t.count = count_of[k];
					t.total = distinct;
					tally_q.push_back(t);
				end
			end
			if (rsp.valid && rsp.ready) begin
				if (tally_q.size() == 0) begin
					$error("unexpected result word: domain_key %h", rsp.domain_key);
					fail_count++;
				end else begin
					t = tally_q.pop_front();
					got.key = rsp.domain_key;
					got.count = rsp.request_count;
					got.fresh = rsp.new_domain;
					got.total = rsp.domain_total;
					if (got.key !== t.key) begin
						$error("domain_key: expected %h, actual %h", t.key, got.key);
						fail_count++;
					end
					if (got.count !== t.count) begin
						$error("request_count: expected %0d, actual %0d", t.count, got.count);
						fail_count++;
					end
					if (got.fresh !== t.fresh) begin
						$error("new_domain: expected %b, actual %b", t.fresh, got.fresh);
						fail_count++;
					end
					if (got.total !== t.total) begin
						$error("domain_total: expected %0d, actual %0d", t.total, got.total);
						fail_count++;
					end
				end
			end
		end
		pending = tally_q.size();
	end

endmodule

/* test/tb_top.sv */
module tb_top import drrc_pkg::*; ();

	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_GOAL = 1600;
	localparam int POOL = 12;
	localparam int POOL_LEN = 16;
	localparam int NAME_MAX = 300;

	logic clk = 1'b0;
	logic arst_n;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycles;
	int src_idle;
	int dst_idle;
	int bytes_sent;
	logic [7:0] name_buf[NAME_MAX];
	logic [7:0] pool_bytes[POOL][POOL_LEN];
	int pool_len[POOL];
	logic [SLICE_W-1:0] cur_slice;

	drrc_in_if req();
	drrc_out_if rsp();

	domain_request_rate_counter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	drrc_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #4 clk = ~clk;

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= ($urandom_range(99) >= dst_idle);
			cycles <= cycles + 1;
			if (cycles == CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic lst, input logic [SLICE_W-1:0] s);
		if (bytes_sent < ITEM_GOAL / 3) begin
			src_idle = 21;
			dst_idle = 80;
		end else if (bytes_sent < 2 * ITEM_GOAL / 3) begin
			src_idle = 80;
			dst_idle = 21;
		end else begin
			src_idle = 0;
			dst_idle = 0;
		end
		while ($urandom_range(99) < src_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.name_byte <= b;
		req.last_byte <= lst;
		req.time_slice <= s;
		do begin
			@(posedge clk);
		end while (!req.ready);
		bytes_sent++;
	endtask

	task automatic send_name(input int len, input logic [SLICE_W-1:0] s);
		for (int i = 0; i < len; i++) begin
			send_byte(name_buf[i], i == len - 1, (i == len - 1) ? s : $urandom());
		end
	endtask

	task automatic fill_random(input int len);
		for (int i = 0; i < len; i++) begin
			name_buf[i] = 8'($urandom_range(255));
		end
	endtask

	initial begin
		int pick;
		int p;
		int len;
		int zeros;
		bit long_done;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.name_byte <= '0;
		req.last_byte <= 1'b0;
		req.time_slice <= '0;
		src_idle = 21;
		dst_idle = 80;
		long_done = 1'b0;
		cur_slice = 32'hFFFF_FFF0;
		for (int q = 0; q < POOL; q++) begin
			pool_len[q] = $urandom_range(1, POOL_LEN);
			for (int i = 0; i < POOL_LEN; i++) begin
				pool_bytes[q][i] = 8'($urandom_range(255));
			end
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// A lone zero byte and two zero bytes both give key zero.
		name_buf[0] = 8'h00;
		send_name(1, 32'h0000_0000);
		name_buf[1] = 8'h00;
		send_name(2, 32'h0000_0000);
		name_buf[0] = 8'hFF;
		send_name(1, 32'hFFFF_FFFF);
		send_name(1, 32'hFFFF_FFFF);
		send_name(1, 32'h0000_0000);
		name_buf[0] = 8'h00;
		name_buf[1] = 8'hFF;
		send_name(2, 32'h0000_0000);
		name_buf[0] = 8'h61;
		name_buf[1] = 8'h2E;
		name_buf[2] = 8'h63;
		name_buf[3] = 8'h6F;
		name_buf[4] = 8'h6D;
		send_name(5, 32'h8000_0001);
		send_name(5, 32'h8000_0001);
		name_buf[0] = 8'h55;
		name_buf[1] = 8'hAA;
		name_buf[2] = 8'h80;
		name_buf[3] = 8'h01;
		send_name(4, 32'h7FFF_FFFE);

		while (bytes_sent < ITEM_GOAL) begin
			pick = $urandom_range(99);
			p = $urandom_range(POOL - 1);
			if ($urandom_range(99) < 15) begin
				cur_slice = cur_slice + 1;
			end else if ($urandom_range(99) < 5) begin
				cur_slice = $urandom();
			end
			if (!long_done && bytes_sent > ITEM_GOAL / 2) begin
				long_done = 1'b1;
				len = $urandom_range(256, NAME_MAX);
				fill_random(len);
			end else if (pick < 60) begin
				len = pool_len[p];
				for (int i = 0; i < len; i++) begin
					name_buf[i] = pool_bytes[p][i];
				end
			end else if (pick < 68) begin
				// Leading zero bytes leave the key unchanged.
				zeros = $urandom_range(1, 3);
				len = zeros + pool_len[p];
				for (int i = 0; i < zeros; i++) begin
					name_buf[i] = 8'h00;
				end
				for (int i = 0; i < pool_len[p]; i++) begin
					name_buf[zeros + i] = pool_bytes[p][i];
				end
			end else if (pick < 96) begin
				len = $urandom_range(1, POOL_LEN);
				fill_random(len);
				pool_len[p] = len;
				for (int i = 0; i < len; i++) begin
					pool_bytes[p][i] = name_buf[i];
				end
			end else begin
				len = $urandom_range(POOL_LEN + 1, 255);
				fill_random(len);
			end
			send_name(len, cur_slice);
		end
		req.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
